[rtl/core/i2cts_pkg.sv]
// ----------------------------------------------------------------------------
// i2cts_pkg
// Shared types and constants for the I2C target byte sequencer.
// ----------------------------------------------------------------------------
package i2cts_pkg;

    localparam int ADDR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int RELOAD_W  = 4;
    localparam int REPLY_W   = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register indexes
    localparam logic REG_OWN_ADDRESS = 1'b0;
    localparam logic REG_START_HOOK  = 1'b1;

    // event kinds
    localparam logic CMD_START      = 1'b0;
    localparam logic CMD_COUNT_DONE = 1'b1;

    // consumer replies
    localparam logic [REPLY_W-1:0] REPLY_OK   = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_LAST = 2'd1;

    localparam logic [RELOAD_W-1:0] RELOAD_NONE = 4'd0;
    localparam logic [RELOAD_W-1:0] RELOAD_BIT  = 4'd1;
    localparam logic [RELOAD_W-1:0] RELOAD_BYTE = 4'd8;

    localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] NACK_BYTE = 8'hFF;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_CHECK    = 8'b0000_0010,
        PH_RECV     = 8'b0000_0100,
        PH_RECV_ACK = 8'b0000_1000,
        PH_SEND     = 8'b0001_0000,
        PH_SEND_REP = 8'b0010_0000,
        PH_SEND_ACK = 8'b0100_0000,
        PH_RELEASE  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic                command;
        logic [BYTE_W-1:0]   shift_data;
        logic [REPLY_W-1:0]  receive_reply;
        logic [BYTE_W-1:0]   transmit_byte;
    } event_t;

    typedef struct packed {
        logic                drive_enable;
        logic [RELOAD_W-1:0] count_reload;
        logic                load_valid;
        logic [BYTE_W-1:0]   load_value;
        logic                start_pulse;
        logic                byte_valid;
        logic [BYTE_W-1:0]   received_byte;
        logic                send_taken;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   own_address;
        logic                start_hook_enabled;
    } cfg_t;

endpackage

[rtl/core/i2cts_apb_regs.sv]
// ----------------------------------------------------------------------------
// i2cts_apb_regs
// APB register file: own address and start hook enable.
// ----------------------------------------------------------------------------
module i2cts_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cts_pkg::APB_AW-1:0] paddr,
    input  logic [i2cts_pkg::APB_DW-1:0] pwdata,
    output logic [i2cts_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output i2cts_pkg::cfg_t             cfg
);
    import i2cts_pkg::*;

    logic [ADDR_W-1:0] own_address_reg;
    logic              start_hook_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            start_hook_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_OWN_ADDRESS: own_address_reg <= pwdata[ADDR_W-1:0];
                REG_START_HOOK:  start_hook_reg  <= pwdata[0];
                default:         own_address_reg <= own_address_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_OWN_ADDRESS: prdata = {{(APB_DW-ADDR_W){1'b0}}, own_address_reg};
            REG_START_HOOK:  prdata = {{(APB_DW-1){1'b0}}, start_hook_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.own_address        = own_address_reg;
    assign cfg.start_hook_enabled = start_hook_reg;

endmodule

[rtl/core/i2cts_phase_fsm.sv]
// ----------------------------------------------------------------------------
// i2cts_phase_fsm
// Phase and driver state; computes one result word per event.
// ----------------------------------------------------------------------------
module i2cts_phase_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  i2cts_pkg::event_t   evt,
    input  i2cts_pkg::cfg_t     cfg,
    output i2cts_pkg::result_t  res
);
    import i2cts_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              driver_reg, driver_next;
    logic [BYTE_W-1:0] addr_x;

    // low bit of x selects direction; any higher bit set is a mismatch
    assign addr_x = evt.shift_data ^ {cfg.own_address, 1'b0};

    always_comb
    begin
        phase_next  = phase_reg;
        driver_next = driver_reg;
        res         = '0;
        if (evt.command == CMD_START)
        begin
            driver_next      = 1'b0;
            phase_next       = PH_CHECK;
            res.count_reload = RELOAD_BYTE;
        end
        else
        begin
            case (phase_reg)
                PH_CHECK:
                begin
                    res.load_valid = 1'b1;
                    if (|addr_x[BYTE_W-1:1])
                    begin
                        res.load_value = addr_x;
                        driver_next    = 1'b0;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        driver_next      = 1'b1;
                        res.start_pulse  = cfg.start_hook_enabled;
                        res.load_value   = ACK_BYTE;
                        res.count_reload = RELOAD_BIT;
                        phase_next       = addr_x[0] ? PH_SEND : PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    driver_next      = 1'b0;
                    phase_next       = PH_RECV_ACK;
                    res.count_reload = RELOAD_BYTE;
                end
                PH_RECV_ACK:
                begin
                    driver_next       = 1'b1;
                    res.byte_valid    = 1'b1;
                    res.received_byte = evt.shift_data;
                    res.load_valid    = 1'b1;
                    res.count_reload  = RELOAD_BIT;
                    if (evt.receive_reply == REPLY_OK)
                    begin
                        res.load_value = ACK_BYTE;
                        phase_next     = PH_RECV;
                    end
                    else if (evt.receive_reply == REPLY_LAST)
                    begin
                        res.load_value = ACK_BYTE;
                        phase_next     = PH_RELEASE;
                    end
                    else
                    begin
                        res.load_value = NACK_BYTE;
                        phase_next     = PH_RELEASE;
                    end
                end
                PH_SEND, PH_SEND_REP:
                begin
                    // master NACK ends the read
                    if (phase_reg == PH_SEND_REP && evt.shift_data[0])
                    begin
                        driver_next = 1'b0;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        driver_next      = 1'b1;
                        res.load_valid   = 1'b1;
                        res.load_value   = evt.transmit_byte;
                        res.send_taken   = 1'b1;
                        res.count_reload = RELOAD_BYTE;
                        phase_next       = PH_SEND_ACK;
                    end
                end
                PH_SEND_ACK:
                begin
                    driver_next      = 1'b0;
                    phase_next       = PH_SEND_REP;
                    res.count_reload = RELOAD_BIT;
                end
                PH_RELEASE:
                begin
                    driver_next = 1'b0;
                    phase_next  = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        res.drive_enable = driver_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            driver_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            driver_reg <= driver_next;
        end
    end

endmodule

[rtl/core/i2c_target_byte_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_target_byte_sequencer
// Byte-level I2C target sequencer: steps phase per shift unit event.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              payload
//  event in     in   in_valid / in_ready    command, shift_data, receive_reply,
//                                           transmit_byte
//  result out   out  out_valid / out_ready  drive_enable ... send_taken
//  config       in   APB (psel, penable)    own_address, start_hook_enabled
//
//  Two register stages: event register, then result register. The phase
//  update sits between them, so one word per cycle sustained while the
//  result is not stalled. A stalled result holds both stages; in_ready
//  stays high while the event register can drain. Reset clears phase to
//  idle, driver off, both valid flags and the config registers.
// ----------------------------------------------------------------------------
module i2c_target_byte_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cts_pkg::APB_AW-1:0]        paddr,
    input  logic [i2cts_pkg::APB_DW-1:0]        pwdata,
    output logic [i2cts_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [i2cts_pkg::BYTE_W-1:0]        shift_data,
    input  logic [i2cts_pkg::REPLY_W-1:0]       receive_reply,
    input  logic [i2cts_pkg::BYTE_W-1:0]        transmit_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                drive_enable,
    output logic [i2cts_pkg::RELOAD_W-1:0]      count_reload,
    output logic                                load_valid,
    output logic [i2cts_pkg::BYTE_W-1:0]        load_value,
    output logic                                start_pulse,
    output logic                                byte_valid,
    output logic [i2cts_pkg::BYTE_W-1:0]        received_byte,
    output logic                                send_taken
);
    import i2cts_pkg::*;

    cfg_t    cfg;
    event_t  evt_reg;
    logic    evt_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;

    i2cts_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // event register moves into the result register
    assign advance  = evt_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !evt_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                evt_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            evt_reg.command       <= command;
            evt_reg.shift_data    <= shift_data;
            evt_reg.receive_reply <= receive_reply;
            evt_reg.transmit_byte <= transmit_byte;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    i2cts_phase_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .evt     (evt_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    assign out_valid     = res_valid_reg;
    assign drive_enable  = res_reg.drive_enable;
    assign count_reload  = res_reg.count_reload;
    assign load_valid    = res_reg.load_valid;
    assign load_value    = res_reg.load_value;
    assign start_pulse   = res_reg.start_pulse;
    assign byte_valid    = res_reg.byte_valid;
    assign received_byte = res_reg.received_byte;
    assign send_taken    = res_reg.send_taken;

endmodule
